@@ src/lkpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Lehmer keystream pixel cipher package
// Shared constants, register indexes and types for the cipher block.
// ----------------------------------------------------------------------------
package lkpc_pkg;

  localparam int unsigned GenWidth   = 31;
  localparam int unsigned PixWidth   = 8;
  localparam int unsigned MultWidth  = 15;
  localparam int unsigned ProdWidth  = GenWidth + MultWidth;

  localparam logic [GenWidth-1:0]  LcgMod  = 31'h7FFF_FFFF;
  localparam logic [MultWidth-1:0] LcgMult = 15'd16807;

  // Remainder unit: four dividend bits per step, a zero bit and the 31
  // generator bits, then 8 pixel bits.
  localparam int unsigned BitsPerStep = 4;
  localparam int unsigned DivBits     = 40;
  localparam int unsigned DivSteps    = DivBits / BitsPerStep;
  localparam int unsigned KeySteps    = 32 / BitsPerStep;
  localparam int unsigned StepWidth   = 4;

  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = 1;

  localparam int unsigned AddrWidth   = 4;
  localparam int unsigned DataWidth   = 32;

  typedef enum logic [1:0] {
    RegSeedKey    = 2'd0,
    RegPixelMax   = 2'd1,
    RegCipherMode = 2'd2
  } reg_idx_e;

  typedef enum logic {
    ModeEncode = 1'b0,
    ModeDecode = 1'b1
  } cipher_mode_e;

  typedef struct packed {
    logic [GenWidth-1:0] gen_value;
    logic [PixWidth-1:0] pixel;
  } lkpc_item_t;

  typedef struct packed {
    logic [PixWidth-1:0] pixel_max;
    cipher_mode_e        mode;
  } lkpc_cfg_t;

endpackage

@@ src/lehmer_keystream_pixel_cipher.sv @@
// ----------------------------------------------------------------------------
// Lehmer keystream pixel cipher
// A shared remainder unit reduces 40 bits four at a time between a load
// step and a finish step, and takes a new pixel only after the last one.
// The generator stage runs ahead through a two-entry queue. Reset clears
// the generator, empties the queue and the output stage and sets the
// configuration registers to their reset values.
// ----------------------------------------------------------------------------
module lehmer_keystream_pixel_cipher import lkpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  input  logic                 push,
  output logic                 full,
  input  logic [PixWidth-1:0]  pixel_in_i,
  input  logic                 first_of_image_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [PixWidth-1:0]  pixel_out_o
);

  logic [GenWidth-1:0] seed_key_q;
  logic [PixWidth-1:0] pixel_max_q;
  cipher_mode_e        cipher_mode_q;
  logic                wr_en;
  reg_idx_e            reg_idx;
  lkpc_cfg_t           cfg;

  logic                q_push;
  lkpc_item_t          q_wr_item;
  logic                q_full;
  logic                q_pop;
  lkpc_item_t          q_rd_item;
  logic                q_empty;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[AddrWidth-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_key_q    <= '0;
      pixel_max_q   <= '1;
      cipher_mode_q <= ModeEncode;
    end else if (wr_en) begin
      case (reg_idx)
        RegSeedKey:    seed_key_q    <= pwdata[GenWidth-1:0];
        RegPixelMax:   pixel_max_q   <= pwdata[PixWidth-1:0];
        RegCipherMode: cipher_mode_q <= cipher_mode_e'(pwdata[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegSeedKey:    prdata = {{(DataWidth-GenWidth){1'b0}}, seed_key_q};
      RegPixelMax:   prdata = {{(DataWidth-PixWidth){1'b0}}, pixel_max_q};
      RegCipherMode: prdata = {{(DataWidth-1){1'b0}}, cipher_mode_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg.pixel_max = pixel_max_q;
  assign cfg.mode      = cipher_mode_q;

  lkpc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .pixel_in_i       (pixel_in_i),
    .first_of_image_i (first_of_image_i),
    .seed_key_i       (seed_key_q),
    .q_push_o         (q_push),
    .q_item_o         (q_wr_item),
    .q_full_i         (q_full)
  );

  lkpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_rd_item),
    .empty_o (q_empty)
  );

  lkpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_item_i    (q_rd_item),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .pixel_out_o (pixel_out_o)
  );

endmodule

@@ src/lkpc_front.sv @@
// ----------------------------------------------------------------------------
// Lehmer keystream front end
// Accepts pixels, reloads and advances the Park-Miller generator and hands
// each generator value with its pixel to the work queue.
// ----------------------------------------------------------------------------
module lkpc_front import lkpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [PixWidth-1:0] pixel_in_i,
  input  logic                first_of_image_i,
  input  logic [GenWidth-1:0] seed_key_i,
  output logic                q_push_o,
  output lkpc_item_t          q_item_o,
  input  logic                q_full_i
);

  typedef enum logic {
    FrIdle,
    FrMul
  } front_state_e;

  front_state_e         state_q;
  logic [GenWidth-1:0]  gen_q;
  logic [ProdWidth-1:0] product_q;
  logic [PixWidth-1:0]  pixel_q;

  logic [GenWidth-1:0]  operand;
  logic [ProdWidth-1:0] product_d;
  logic [GenWidth:0]    fold;
  logic [GenWidth-1:0]  reduced;
  logic                 accept;

  assign full     = (state_q != FrIdle);
  assign accept   = push && !full;
  assign operand  = first_of_image_i ? seed_key_i : gen_q;
  assign product_d = {{MultWidth{1'b0}}, operand} * {{GenWidth{1'b0}}, LcgMult};

  // 2^31 is congruent to 1 modulo 2^31 - 1, so the high part folds onto the low.
  assign fold    = {1'b0, product_q[GenWidth-1:0]}
                 + {{(GenWidth+1-MultWidth){1'b0}}, product_q[ProdWidth-1:GenWidth]};
  assign reduced = (fold >= {1'b0, LcgMod}) ? GenWidth'(fold - {1'b0, LcgMod})
                                            : fold[GenWidth-1:0];

  assign q_push_o           = (state_q == FrMul) && !q_full_i;
  assign q_item_o.gen_value = reduced;
  assign q_item_o.pixel     = pixel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      gen_q   <= '0;
    end else begin
      case (state_q)
        FrIdle: begin
          if (accept) begin
            state_q <= FrMul;
          end
        end
        FrMul: begin
          if (!q_full_i) begin
            gen_q   <= reduced;
            state_q <= FrIdle;
          end
        end
        default: state_q <= FrIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      product_q <= product_d;
      pixel_q   <= pixel_in_i;
    end
  end

endmodule

@@ src/lkpc_queue.sv @@
// ----------------------------------------------------------------------------
// Lehmer keystream work queue
// Short first-in first-out queue between the front end and the remainder unit.
// ----------------------------------------------------------------------------
module lkpc_queue import lkpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  lkpc_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output lkpc_item_t item_o,
  output logic       empty_o
);

  lkpc_item_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q;
  logic [QueuePtrW-1:0]   rd_ptr_q;
  logic [QueuePtrW:0]     count_q;
  logic                   do_push;
  logic                   do_pop;

  assign full_o  = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ src/lkpc_back.sv @@
// ----------------------------------------------------------------------------
// Lehmer keystream back end
// Reduces the generator value and the pixel modulo pixel_max + 1 four bits
// per cycle, combines them and holds the result for transfer.
// ----------------------------------------------------------------------------
module lkpc_back import lkpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lkpc_cfg_t           cfg_i,
  input  lkpc_item_t          q_item_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  output logic                empty,
  input  logic                pop,
  output logic [PixWidth-1:0] pixel_out_o
);

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkDone
  } back_state_e;

  back_state_e           state_q;
  logic [StepWidth-1:0]  step_q;
  logic [DivBits-1:0]    shift_q;
  logic [PixWidth-1:0]   rem_q;
  logic [PixWidth-1:0]   key_q;
  logic                  out_valid_q;
  logic                  out_valid_d;
  logic [PixWidth-1:0]   pixel_out_q;

  logic [PixWidth:0]     modulus;
  logic [PixWidth-1:0]   rem_next;
  logic [PixWidth:0]     sum;
  logic [PixWidth:0]     sum_red;
  logic                  out_free;

  function automatic logic [PixWidth-1:0] div_steps(
    input logic [PixWidth-1:0]    rem,
    input logic [BitsPerStep-1:0] bits,
    input logic [PixWidth:0]      m
  );
    logic [PixWidth:0] t;
    logic [PixWidth:0] r;
    r = {1'b0, rem};
    for (int i = BitsPerStep - 1; i >= 0; i--) begin
      t = {r[PixWidth-1:0], bits[i]};
      r = (t >= m) ? (t - m) : t;
    end
    return r[PixWidth-1:0];
  endfunction

  assign modulus  = {1'b0, cfg_i.pixel_max} + 1'b1;
  assign rem_next = div_steps(rem_q, shift_q[DivBits-1 -: BitsPerStep], modulus);

  always_comb begin
    if (cfg_i.mode == ModeDecode) begin
      sum = {1'b0, rem_q} + modulus - {1'b0, key_q};
    end else begin
      sum = {1'b0, rem_q} + {1'b0, key_q};
    end
    sum_red = (sum >= modulus) ? (sum - modulus) : sum;
  end

  assign out_free    = !out_valid_q || pop;
  assign q_pop_o     = (state_q == BkIdle) && !q_empty_i;
  assign empty       = !out_valid_q;
  assign pixel_out_o = pixel_out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == BkDone) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        BkIdle: begin
          if (!q_empty_i) begin
            step_q  <= '0;
            state_q <= BkDiv;
          end
        end
        BkDiv: begin
          step_q <= step_q + 1'b1;
          if (step_q == StepWidth'(DivSteps - 1)) begin
            state_q <= BkDone;
          end
        end
        BkDone: begin
          if (out_free) begin
            state_q <= BkIdle;
          end
        end
        default: state_q <= BkIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BkIdle: begin
        shift_q <= {1'b0, q_item_i.gen_value, q_item_i.pixel};
        rem_q   <= '0;
      end
      BkDiv: begin
        shift_q <= shift_q << BitsPerStep;
        if (step_q == StepWidth'(KeySteps - 1)) begin
          key_q <= rem_next;
          rem_q <= '0;
        end else begin
          rem_q <= rem_next;
        end
      end
      BkDone: begin
        if (out_free) begin
          pixel_out_q <= sum_red[PixWidth-1:0];
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkDiv) |-> ({1'b0, rem_q} < modulus))
    else $error("Partial remainder is not below the modulus.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkDone) |-> ({1'b0, key_q} < modulus && {1'b0, rem_q} < modulus))
    else $error("Key or reduced pixel is not below the modulus.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkDiv && step_q == StepWidth'(DivSteps - 1)) |=> (state_q == BkDone))
    else $error("Remainder unit did not finish after the last step.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkDiv) |-> (step_q < StepWidth'(DivSteps)))
    else $error("Remainder step counter ran past the last step.");
`endif

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Lehmer keystream pixel cipher testbench
// Pushes pixel streams through the cipher under changing seed, pixel range
// and mode settings, predicts every output pixel from a local copy of the
// Park-Miller generator, and checks each transfer on the output side in
// order. Both sides stall at random in the random phases but the last, and
// the configuration is read back after each write to a defined register.
// ----------------------------------------------------------------------------
module tb_top;
  import lkpc_pkg::*;

  localparam logic [1:0] RegReserved = 2'd3;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 80;
  localparam int unsigned RandPhases = 8;

  typedef struct packed {
    logic [PixWidth-1:0] pixel;
    logic                first;
  } pix_req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  logic                 push = 1'b0;
  logic                 full;
  logic [PixWidth-1:0]  pixel_in_i = '0;
  logic                 first_of_image_i = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [PixWidth-1:0]  pixel_out_o;

  lehmer_keystream_pixel_cipher dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .push             (push),
    .full             (full),
    .pixel_in_i       (pixel_in_i),
    .first_of_image_i (first_of_image_i),
    .empty            (empty),
    .pop              (pop),
    .pixel_out_o      (pixel_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [GenWidth-1:0] seed_reg = '0;
  logic [PixWidth-1:0] pmax_reg = 8'd255;
  cipher_mode_e        mode_reg = ModeEncode;
  logic [GenWidth-1:0] gen_state = '0;

  pix_req_t            pixel_queue[$];
  logic [PixWidth-1:0] expected_pixels[$];
  pix_req_t            next_req;
  logic                in_xfer = 1'b0;
  logic                quiet = 1'b0;
  int unsigned         gap_pct = 0;
  int unsigned         stall_pct = 0;
  int unsigned         send_gap = 0;
  int unsigned         pop_gap = 0;
  int unsigned         cycles = 0;
  int unsigned         errors = 0;

  function automatic logic [GenWidth-1:0] lcg_advance(logic [GenWidth-1:0] r);
    logic [63:0] prod;
    prod = 64'(r) * 64'(LcgMult);
    return GenWidth'(prod % 64'(LcgMod));
  endfunction

  function automatic logic [PixWidth-1:0] cipher_pixel(logic [PixWidth-1:0] pix,
                                                        logic first);
    int unsigned modulus;
    int unsigned key;
    int unsigned res;
    if (first) begin
      gen_state = seed_reg;
    end
    gen_state = lcg_advance(gen_state);
    modulus = int'(pmax_reg) + 1;
    key = gen_state % modulus;
    if (mode_reg == ModeDecode) begin
      res = (pix + modulus - key) % modulus;
    end else begin
      res = (pix + key) % modulus;
    end
    return PixWidth'(res);
  endfunction

  // Prediction on each input transfer, checking on each output transfer.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else if (rst_ni) begin
      in_xfer = push && !full;
      if (in_xfer) begin
        expected_pixels.push_back(cipher_pixel(pixel_in_i, first_of_image_i));
      end
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel_out: no result expected, got %0d", pixel_out_o);
          errors++;
        end else if (pixel_out_o !== expected_pixels[0]) begin
          $error("pixel_out: expected %0d, got %0d", expected_pixels[0], pixel_out_o);
          errors++;
          void'(expected_pixels.pop_front());
        end else begin
          void'(expected_pixels.pop_front());
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!push || in_xfer)) begin
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
        send_gap = $urandom_range(0, 2);
        push <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        next_req = pixel_queue.pop_front();
        push <= 1'b1;
        pixel_in_i <= next_req.pixel;
        first_of_image_i <= next_req.first;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        pop_gap = $urandom_range(0, 2);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic queue_pixel(logic [PixWidth-1:0] pix, logic first);
    pixel_queue.push_back('{pixel: pix, first: first});
  endtask

  task automatic wait_drained();
    while (pixel_queue.size() != 0 || push || expected_pixels.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Called at a falling edge while the block is idle; returns at a falling edge.
  task automatic reg_write(logic [1:0] idx, logic [DataWidth-1:0] data);
    logic [DataWidth-1:0] rd_data;
    logic [DataWidth-1:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrWidth'({idx, 2'b00});
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegSeedKey:    seed_reg = data[GenWidth-1:0];
      RegPixelMax:   pmax_reg = data[PixWidth-1:0];
      RegCipherMode: mode_reg = cipher_mode_e'(data[0]);
      default: ;
    endcase
    @(negedge clk_i);
    if (idx == RegReserved) begin
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
    end else begin
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      rd_data = prdata;
      case (idx)
        RegSeedKey:  readback = DataWidth'(seed_reg);
        RegPixelMax: readback = DataWidth'(pmax_reg);
        default:     readback = DataWidth'(mode_reg);
      endcase
      if (rd_data !== readback) begin
        $error("prdata: expected %0h, got %0h", readback, rd_data);
        errors++;
      end
      @(negedge clk_i);
      psel <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  function automatic logic [DataWidth-1:0] pick_seed();
    case ($urandom_range(0, 9))
      0:       return {$urandom_range(0, 1) == 1, 31'd0};
      1:       return {$urandom_range(0, 1) == 1, 31'h7FFF_FFFF};
      2:       return 32'h7FFF_FFFE;
      3:       return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DataWidth-1:0] pick_pmax();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'd255;
      2:       return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_pixels(int unsigned count);
    int unsigned n;
    int unsigned len;
    logic [PixWidth-1:0] pix;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_pixel(PixWidth'($urandom_range(0, 255)), $urandom_range(0, 1) == 1);
        n++;
      end else begin
        len = $urandom_range(1, 24);
        for (int k = 0; k < len && n < count; k++) begin
          if ($urandom_range(0, 99) < 85) begin
            pix = PixWidth'($urandom_range(0, pmax_reg));
          end else begin
            pix = PixWidth'($urandom_range(0, 255));
          end
          queue_pixel(pix, k == 0 && $urandom_range(0, 7) != 0);
          n++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // No image start seen yet, then the reset seed of zero.
    queue_pixel(8'h00, 1'b0);
    queue_pixel(8'hFF, 1'b0);
    queue_pixel(8'hA5, 1'b0);
    queue_pixel(8'h5A, 1'b1);
    wait_drained();
    reg_write(RegSeedKey, 32'h7FFF_FFFF);
    queue_pixel(8'h5A, 1'b1);
    queue_pixel(8'hFF, 1'b0);
    wait_drained();
    reg_write(RegSeedKey, 32'h8000_0001);
    queue_pixel(8'hFF, 1'b1);
    queue_pixel(8'h00, 1'b0);
    queue_pixel(8'h80, 1'b0);
    queue_pixel(8'h7F, 1'b0);
    wait_drained();
    reg_write(RegCipherMode, DataWidth'(ModeDecode));
    queue_pixel(8'hFF, 1'b1);
    queue_pixel(8'h00, 1'b0);
    queue_pixel(8'h80, 1'b0);
    queue_pixel(8'h7F, 1'b0);
    wait_drained();
    reg_write(RegPixelMax, 32'h0000_FF00);
    queue_pixel(8'hFF, 1'b0);
    queue_pixel(8'h00, 1'b0);
    wait_drained();
    reg_write(RegPixelMax, 32'd100);
    queue_pixel(8'd200, 1'b0);
    queue_pixel(8'd255, 1'b1);
    wait_drained();
    reg_write(RegCipherMode, 32'hFFFF_FFFE);
    queue_pixel(8'd200, 1'b0);
    queue_pixel(8'd101, 1'b0);
    wait_drained();
    reg_write(RegSeedKey, 32'h7FFF_FFFE);
    reg_write(RegPixelMax, 32'hFFFF_FFFF);
    reg_write(RegReserved, 32'hFFFF_FFFF);
    queue_pixel(8'h33, 1'b1);
    queue_pixel(8'hCC, 1'b0);
    wait_drained();

    for (int p = 0; p < RandPhases; p++) begin
      if (p == 0) begin
        reg_write(RegPixelMax, 32'd255);
      end else if ($urandom_range(0, 1) == 1) begin
        reg_write(RegPixelMax, pick_pmax());
      end
      if (p == 0 || $urandom_range(0, 1) == 1) begin
        reg_write(RegSeedKey, pick_seed());
      end
      if ($urandom_range(0, 1) == 1) begin
        reg_write(RegCipherMode, $urandom);
      end
      quiet = (p == RandPhases - 1);
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
      queue_random_pixels(PhaseItems);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
